// ===== src/ztsc_pkg.sv =====
// Package for the Zhuyin tone syllable checker: types, constants and key classes.
package ztsc_pkg;

   localparam int MAX_KEYS = 64;
   localparam int POS_W    = 7;
   localparam int TONE_W   = 6;
   localparam logic [POS_W-1:0] KEY_CAP =
      (MAX_KEYS > 127) ? POS_W'(127) : POS_W'(MAX_KEYS);
   localparam logic [TONE_W-1:0] TONE_CAP = '1;

   typedef enum logic [1:0] {
      CAT_NONE    = 2'd0,
      CAT_INITIAL = 2'd1,
      CAT_MEDIAL  = 2'd2,
      CAT_FINAL   = 2'd3
   } category_type;

   typedef struct packed {
      logic         tone;
      logic         apical;
      category_type category;
   } key_info_type;

   typedef struct packed {
      logic [1:0]        chunk_length;
      logic              chunk_invalid;
      category_type      previous_category;
      logic              first_is_apical;
      logic              fail_flag;
      logic              seen_tone;
      logic [POS_W-1:0]  key_position;
      logic [POS_W-1:0]  boundary_position;
      logic [TONE_W-1:0] tone_count;
      logic              overflow_flag;
   } state_type;

   typedef struct packed {
      logic              too_long;
      logic              failed;
      logic [TONE_W-1:0] syllable_count;
      logic [POS_W-1:0]  prefix_length;
      logic              ready_for_tone;
      logic              all_toned;
   } result_type;

   localparam int RESULT_W = $bits(result_type);
   localparam int RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== src/ztsc_key_decode.sv =====
// Key decoder: maps one ASCII key to its Zhuyin class, apical and tone marks.
module ztsc_key_decode
   import ztsc_pkg::*;
(
   input  logic [7:0]   key_code,
   output key_info_type key_info
);

   always_comb begin
      key_info.tone     = 1'b0;
      key_info.apical   = 1'b0;
      key_info.category = CAT_NONE;
      unique case (key_code)
         " ", "3", "4", "6", "7": begin
            key_info.tone = 1'b1;
         end
         "5", "t", "g", "b", "y", "h", "n": begin
            key_info.category = CAT_INITIAL;
            key_info.apical   = 1'b1;
         end
         "1", "q", "a", "z", "2", "w", "s", "x", "e", "d", "c", "r", "f", "v": begin
            key_info.category = CAT_INITIAL;
         end
         "u", "j", "m": begin
            key_info.category = CAT_MEDIAL;
         end
         "i", "k", ",", "9", "o", "l", ".", "0", "p", ";", "/", "-", "8": begin
            key_info.category = CAT_FINAL;
         end
         default: begin
            key_info.category = CAT_NONE;
         end
      endcase
   end

endmodule

// ===== src/ztsc_core.sv =====
// Syllable state tracker: per-key chunk update and next result.
module ztsc_core
   import ztsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   key_code,
   input  logic         last_key,
   output result_type   result
);

   key_info_type key_info;
   state_type    state_ff;
   state_type    state_in;
   state_type    state_nx;
   logic         cur_complete;
   logic         nx_complete;

   ztsc_key_decode u_decode (
      .key_code (key_code),
      .key_info (key_info)
   );

   function automatic logic chunk_complete(input state_type s);
      logic ok;
      ok = 1'b0;
      if ((s.chunk_length != 2'd0) && !s.chunk_invalid) begin
         ok = (s.previous_category == CAT_MEDIAL) || (s.previous_category == CAT_FINAL) ||
              ((s.chunk_length == 2'd1) && s.first_is_apical);
      end
      return ok;
   endfunction

   assign cur_complete = chunk_complete(state_ff);

   always_comb begin
      state_nx = state_ff;
      if (state_ff.key_position >= KEY_CAP) begin
         state_nx.overflow_flag = 1'b1;
      end else begin
         state_nx.key_position = state_ff.key_position + POS_W'(1);
      end
      if (!state_ff.fail_flag) begin
         if (key_info.tone) begin
            if (!cur_complete) begin
               state_nx.fail_flag = 1'b1;
            end else begin
               state_nx.chunk_length      = 2'd0;
               state_nx.chunk_invalid     = 1'b0;
               state_nx.previous_category = CAT_NONE;
               state_nx.first_is_apical   = 1'b0;
               state_nx.seen_tone         = 1'b1;
               state_nx.boundary_position = state_nx.key_position;
               if (state_ff.tone_count < TONE_CAP) begin
                  state_nx.tone_count = state_ff.tone_count + TONE_W'(1);
               end
            end
         end else if (state_ff.chunk_length == 2'd3) begin
            state_nx.chunk_invalid = 1'b1;
         end else begin
            if ((key_info.category == CAT_NONE) ||
                (key_info.category <= state_ff.previous_category)) begin
               state_nx.chunk_invalid = 1'b1;
            end
            if (state_ff.chunk_length == 2'd0) begin
               state_nx.first_is_apical = key_info.apical;
            end
            state_nx.previous_category = key_info.category;
            state_nx.chunk_length      = state_ff.chunk_length + 2'd1;
         end
      end
   end

   assign nx_complete = chunk_complete(state_nx);

   always_comb begin
      result.all_toned      = !state_nx.fail_flag && state_nx.seen_tone &&
                              (state_nx.chunk_length == 2'd0);
      result.ready_for_tone = !state_nx.fail_flag && nx_complete;
      result.prefix_length  = state_nx.boundary_position;
      result.syllable_count = (!state_nx.fail_flag && (state_nx.chunk_length == 2'd0)) ?
                              state_nx.tone_count : '0;
      result.failed         = state_nx.fail_flag;
      result.too_long       = state_nx.overflow_flag;
   end

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = last_key ? '0 : state_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // string end clears everything
   assert property (@(posedge clock) disable iff (reset)
      accept && last_key |=> state_ff == '0)
      else $error("state not cleared after last key");

   // failure is sticky within a string
   assert property (@(posedge clock) disable iff (reset)
      accept && !last_key && state_ff.fail_flag |=> state_ff.fail_flag)
      else $error("failure flag dropped mid-string");

   // after a failure the boundary holds
   assert property (@(posedge clock) disable iff (reset)
      accept && !last_key && state_ff.fail_flag |=>
         state_ff.boundary_position == $past(state_ff.boundary_position))
      else $error("boundary moved after failure");

endmodule

// ===== src/zhuyin_tone_syllable_checker.sv =====
// Top level of the Zhuyin tone syllable checker with registered result stage.
//
// Usage:
//   req_* channel carries one typed key per transaction: req_tdata[7:0] is the
//   ASCII key code, req_tlast marks the final key of a key string.
//   rsp_* channel returns one result per key, in the cycle after the key is taken.
//   Throughput is one key per cycle while rsp_tready stays high. The key classifier
//   and state update sit between the state registers and the result register.
//   A key is taken whenever the result register is empty or being drained in
//   the same cycle, so keys flow back to back while rsp_tready stays high.
//   When the receiver stalls, the result holds in its register and req_tready
//   drops until it is taken.
//   After the key flagged by req_tlast, all syllable state returns to zero.
//   Synchronous reset clears the state and empties the result register.
module zhuyin_tone_syllable_checker
   import ztsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] key_code
   input  logic                  req_tlast,   // last_key
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] all_toned, [1] ready_for_tone, [8:2] prefix_length,
   // [14:9] syllable_count, [15] failed, [16] too_long, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       accept;
   result_type result;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   ztsc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .key_code (req_tdata),
      .last_key (req_tlast),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   // every accepted key yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted key produced no result");

   // a stalled result blocks new keys
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("key accepted over a stalled result");

   // a failed result never reports readiness or completion
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_data_ff.failed |->
         !rsp_data_ff.ready_for_tone && !rsp_data_ff.all_toned &&
         (rsp_data_ff.syllable_count == '0))
      else $error("failed result with success fields set");

endmodule
